// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of the planner core.
// Depends on nothing; every macro takes a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("planner core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("planner core assertion failed");

`endif

// ===== rtl/core/ctp_pkg.sv =====
// Package of the constrained trajectory planner core: widths, constants,
// datapath command codes and the command and status structs. No dependencies.
package ctp_pkg;

    localparam int DW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int LIM_W     = 31;
    localparam int TS_W      = 32;

    // One in value format, and the 0.001 scale of the velocity deadband.
    localparam logic [DW-1:0] ONE_Q  = DW'(1) << FRAC_BITS;
    localparam logic [31:0]   THOUS  = 32'd4294967;
    // Rounding halves for shifts by the fraction width and by 32.
    localparam logic [65:0]   HALF16 = 66'(1) << (FRAC_BITS - 1);
    localparam logic [65:0]   HALF32 = 66'(1) << 31;
    localparam logic [60:0]   TERM_CAP = 61'(1) << 60;

    // Number of quotient bits produced by the shared divider.
    localparam int DIV_STEPS = 31;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACCEL = 2'd0;
    localparam logic [1:0] CFG_VLIM  = 2'd1;
    localparam logic [1:0] CFG_WN    = 2'd2;
    localparam logic [1:0] CFG_TS    = 2'd3;

    typedef logic [4:0] t_op;

    // Datapath command codes.
    localparam t_op OP_NOP        = 5'd0;
    localparam t_op OP_CAP        = 5'd1;
    localparam t_op OP_MUL_BRAKE  = 5'd2;
    localparam t_op OP_MUL_VE2    = 5'd3;
    localparam t_op OP_MUL_THR    = 5'd4;
    localparam t_op OP_MUL_KIN    = 5'd5;
    localparam t_op OP_KDIV_INIT  = 5'd6;
    localparam t_op OP_DIV_STEP   = 5'd7;
    localparam t_op OP_KIN_ACC    = 5'd8;
    localparam t_op OP_WRONG_ACC  = 5'd9;
    localparam t_op OP_MUL_W2     = 5'd10;
    localparam t_op OP_SAVE_W2    = 5'd11;
    localparam t_op OP_MUL_W2LO   = 5'd12;
    localparam t_op OP_MUL_W2HI   = 5'd13;
    localparam t_op OP_MUL_DAMP   = 5'd14;
    localparam t_op OP_SAVE_T1    = 5'd15;
    localparam t_op OP_TRACK_ACC  = 5'd16;
    localparam t_op OP_MUL_VEL    = 5'd17;
    localparam t_op OP_VEL        = 5'd18;
    localparam t_op OP_MUL_POS    = 5'd19;
    localparam t_op OP_POS        = 5'd20;
    localparam t_op OP_COMMIT     = 5'd21;
    localparam t_op OP_FIN        = 5'd22;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic item_step;
        logic kin_sel;
        logic wrong_sel;
        logic ts_zero;
    } t_stat;

endpackage

// ===== rtl/core/ctp_intf.sv =====
// Channel interfaces of the planner core: input request, result and
// configuration write. Depends on ctp_pkg for the field widths.
interface ctp_in_if;
    import ctp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic signed [DW-1:0] goal_position;
    logic signed [DW-1:0] goal_velocity;
    logic signed [DW-1:0] goal_accel;
    modport source(output valid, operation, goal_position, goal_velocity, goal_accel,
                   input ready);
    modport sink(input valid, operation, goal_position, goal_velocity, goal_accel,
                 output ready);
endinterface

interface ctp_out_if;
    import ctp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] planned_position;
    logic signed [DW-1:0] planned_velocity;
    logic signed [DW-1:0] applied_accel;
    modport source(output valid, planned_position, planned_velocity, applied_accel,
                   input ready);
    modport sink(input valid, planned_position, planned_velocity, applied_accel,
                 output ready);
endinterface

interface ctp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/ctp_ctrl.sv =====
// Sequencer of the planner core: walks each request through the shared
// multiplier and divider steps. Depends on ctp_pkg.
module ctp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ctp_pkg::t_stat i_stat,
    output ctp_pkg::t_cmd  o_cmd
);
    import ctp_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_M1    = 5'd1;
    localparam logic [4:0] S_M2    = 5'd2;
    localparam logic [4:0] S_M3    = 5'd3;
    localparam logic [4:0] S_DEC   = 5'd4;
    localparam logic [4:0] S_K1    = 5'd5;
    localparam logic [4:0] S_KINIT = 5'd6;
    localparam logic [4:0] S_KDIV  = 5'd7;
    localparam logic [4:0] S_KA    = 5'd8;
    localparam logic [4:0] S_W     = 5'd9;
    localparam logic [4:0] S_T1    = 5'd10;
    localparam logic [4:0] S_T2    = 5'd11;
    localparam logic [4:0] S_T3    = 5'd12;
    localparam logic [4:0] S_T4    = 5'd13;
    localparam logic [4:0] S_T5    = 5'd14;
    localparam logic [4:0] S_T6    = 5'd15;
    localparam logic [4:0] S_T7    = 5'd16;
    localparam logic [4:0] S_V1    = 5'd17;
    localparam logic [4:0] S_V2    = 5'd18;
    localparam logic [4:0] S_V3    = 5'd19;
    localparam logic [4:0] S_V4    = 5'd20;
    localparam logic [4:0] S_ADIV  = 5'd21;
    localparam logic [4:0] S_APP   = 5'd22;
    localparam logic [4:0] S_FIN   = 5'd23;

    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    logic [4:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    // Next state and command for the datapath.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd.op    = OP_NOP;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAP;
                    n_state  = i_stat.item_step ? S_M1 : S_FIN;
                end
            end
            S_M1: begin
                o_cmd.op = OP_MUL_BRAKE;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = OP_MUL_VE2;
                n_state  = S_M3;
            end
            S_M3: begin
                o_cmd.op = OP_MUL_THR;
                n_state  = S_DEC;
            end
            S_DEC: begin
                priority if (i_stat.kin_sel) begin
                    n_state = S_K1;
                end else if (i_stat.wrong_sel) begin
                    n_state = S_W;
                end else begin
                    n_state = S_T1;
                end
            end
            S_K1: begin
                o_cmd.op = OP_MUL_KIN;
                n_state  = S_KINIT;
            end
            S_KINIT: begin
                o_cmd.op = OP_KDIV_INIT;
                n_cnt    = '0;
                n_state  = S_KDIV;
            end
            S_KDIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_KA;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_KA: begin
                o_cmd.op = OP_KIN_ACC;
                n_state  = S_V1;
            end
            S_W: begin
                o_cmd.op = OP_WRONG_ACC;
                n_state  = S_V1;
            end
            S_T1: begin
                o_cmd.op = OP_MUL_W2;
                n_state  = S_T2;
            end
            S_T2: begin
                o_cmd.op = OP_SAVE_W2;
                n_state  = S_T3;
            end
            S_T3: begin
                o_cmd.op = OP_MUL_W2LO;
                n_state  = S_T4;
            end
            S_T4: begin
                o_cmd.op = OP_MUL_W2HI;
                n_state  = S_T5;
            end
            S_T5: begin
                o_cmd.op = OP_MUL_DAMP;
                n_state  = S_T6;
            end
            S_T6: begin
                o_cmd.op = OP_SAVE_T1;
                n_state  = S_T7;
            end
            S_T7: begin
                o_cmd.op = OP_TRACK_ACC;
                n_state  = S_V1;
            end
            S_V1: begin
                o_cmd.op = OP_MUL_VEL;
                n_state  = S_V2;
            end
            S_V2: begin
                o_cmd.op = OP_VEL;
                n_state  = S_V3;
            end
            S_V3: begin
                o_cmd.op = OP_MUL_POS;
                n_state  = S_V4;
            end
            S_V4: begin
                o_cmd.op = OP_POS;
                n_cnt    = '0;
                n_state  = i_stat.ts_zero ? S_APP : S_ADIV;
            end
            S_ADIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_APP;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_APP: begin
                o_cmd.op = OP_COMMIT;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // Wait until the result register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_FIN;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/ctp_datapath.sv =====
// Datapath of the planner core: configuration and plan registers, one shared
// 33x33 multiplier, one restoring divider and the result register. Uses ctp_pkg.
module ctp_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ctp_pkg::t_cmd                 i_cmd,
    output ctp_pkg::t_stat                o_stat,
    input  logic                          i_operation,
    input  logic signed [ctp_pkg::DW-1:0] i_goal_position,
    input  logic signed [ctp_pkg::DW-1:0] i_goal_velocity,
    input  logic signed [ctp_pkg::DW-1:0] i_goal_accel,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic signed [ctp_pkg::DW-1:0] o_planned_position,
    output logic signed [ctp_pkg::DW-1:0] o_planned_velocity,
    output logic signed [ctp_pkg::DW-1:0] o_applied_accel
);
    import ctp_pkg::*;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    // Configuration and plan state.
    logic [LIM_W-1:0]     r_amax, r_vlim, r_wn;
    logic [TS_W-1:0]      r_ts;
    logic signed [DW-1:0] r_pp, r_pv, r_la;

    // Captured request and derived errors.
    logic signed [DW-1:0] r_ga;
    logic [31:0]          r_gvmag;
    logic signed [32:0]   r_e, r_ve, r_sum;
    logic [32:0]          r_emag, r_vemag, r_summag;

    // Products and intermediate results.
    logic [65:0]          r_prod;
    logic [64:0]          r_p1;
    logic                 r_tc;
    logic [45:0]          r_w2;
    logic [78:0]          r_acc;
    logic signed [61:0]   r_t1;
    logic signed [DW-1:0] r_a, r_vn, r_pn;
    logic                 r_dvneg;

    // Divider.
    logic [33:0]          r_rem, r_den;
    logic [30:0]          r_nlo, r_quo;
    logic                 r_ovf;

    // Result register.
    logic signed [DW-1:0] r_o_pos, r_o_vel, r_o_acc;

    logic signed [32:0]   c_e, c_ve, c_sum;
    logic [31:0]          c_gvmag;
    logic                 e_pos, e_neg, ve_pos, ve_neg;
    logic [32:0]          mul_a, mul_b;
    logic                 mul_en;
    logic [65:0]          mul_p;
    logic [65:0]          thr_sum, p_r16, p_r32;
    logic signed [34:0]   thr, pv35, pp35;
    logic [79:0]          acc_rnd;
    logic [63:0]          t1m_full;
    logic [60:0]          t1m;
    logic signed [61:0]   t1s;
    logic signed [50:0]   t2s;
    logic signed [63:0]   araw, amax64;
    logic signed [DW-1:0] n_track_a, n_kin_a, n_wrong_a, n_vn, n_pn, n_app;
    logic [30:0]          km;
    logic                 kneg;
    logic signed [34:0]   step35, vraw, praw, vlim35;
    logic [32:0]          amag, vnmag, dvmag;
    logic signed [32:0]   dv;
    logic [64:0]          div_n;
    logic [33:0]          div_d;
    logic [34:0]          div_t;
    logic                 div_ge;

    // Error terms of the incoming request.
    assign c_e     = $signed({i_goal_position[DW-1], i_goal_position}) - $signed({r_pp[DW-1], r_pp});
    assign c_ve    = $signed({r_pv[DW-1], r_pv}) - $signed({i_goal_velocity[DW-1], i_goal_velocity});
    assign c_sum   = $signed({i_goal_velocity[DW-1], i_goal_velocity}) + $signed({r_pv[DW-1], r_pv});
    assign c_gvmag = i_goal_velocity[DW-1] ? 32'(-i_goal_velocity) : 32'(i_goal_velocity);

    assign e_neg  = r_e[32];
    assign e_pos  = !r_e[32] && (r_e != '0);
    assign ve_neg = r_ve[32];
    assign ve_pos = !r_ve[32] && (r_ve != '0);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (i_cmd.op)
            OP_MUL_BRAKE: begin
                mul_a = {1'b0, r_amax, 1'b0};
                mul_b = r_emag;
            end
            OP_MUL_VE2: begin
                mul_a = r_vemag;
                mul_b = r_vemag;
            end
            OP_MUL_THR: begin
                mul_a = {1'b0, r_gvmag};
                mul_b = {1'b0, THOUS};
            end
            OP_MUL_KIN: begin
                mul_a = r_vemag;
                mul_b = r_summag;
            end
            OP_MUL_W2: begin
                mul_a = {2'b0, r_wn};
                mul_b = {2'b0, r_wn};
            end
            OP_MUL_W2LO: begin
                mul_a = {1'b0, r_w2[31:0]};
                mul_b = r_emag;
            end
            OP_MUL_W2HI: begin
                mul_a = {19'b0, r_w2[45:32]};
                mul_b = r_emag;
            end
            OP_MUL_DAMP: begin
                mul_a = {1'b0, r_wn, 1'b0};
                mul_b = r_vemag;
            end
            OP_MUL_VEL: begin
                mul_a = amag;
                mul_b = {1'b0, r_ts};
            end
            OP_MUL_POS: begin
                mul_a = vnmag;
                mul_b = {1'b0, r_ts};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Deadband threshold and branch decision, read while the threshold
    // product sits in the product register.
    assign thr_sum = r_prod + HALF32;
    assign thr     = $signed({1'b0, thr_sum[65:32]}) + $signed({3'b0, ONE_Q});
    assign pv35    = $signed({{3{r_pv[DW-1]}}, r_pv});
    assign pp35    = $signed({{3{r_pp[DW-1]}}, r_pp});

    assign o_stat.item_step = i_operation;
    assign o_stat.kin_sel   = ((e_pos && ve_pos) || (e_neg && ve_neg)) && r_tc;
    assign o_stat.wrong_sel = (e_pos && (pv35 < -thr)) || (e_neg && (pv35 > thr));
    assign o_stat.ts_zero   = (r_ts == '0);

    // Tracking law terms.
    assign acc_rnd  = {1'b0, r_acc} + 80'(HALF16);
    assign t1m_full = acc_rnd[79:16];
    assign t1m      = (t1m_full > 64'(TERM_CAP)) ? TERM_CAP : t1m_full[60:0];
    assign t1s      = e_neg ? -$signed({1'b0, t1m}) : $signed({1'b0, t1m});
    assign p_r16    = r_prod + HALF16;
    assign t2s      = ve_neg ? -$signed({1'b0, p_r16[65:16]}) : $signed({1'b0, p_r16[65:16]});
    assign araw     = 64'(r_t1) - 64'(t2s) + 64'(r_ga);
    assign amax64   = $signed({33'b0, r_amax});

    always_comb begin
        if (araw > amax64) begin
            n_track_a = $signed({1'b0, r_amax});
        end else if (araw < -amax64) begin
            n_track_a = -$signed({1'b0, r_amax});
        end else begin
            n_track_a = araw[DW-1:0];
        end
    end

    // Kinematic braking and wrong-direction accelerations.
    assign km        = (r_ovf || (r_quo > r_amax)) ? r_amax : r_quo;
    assign kneg      = ve_pos ^ r_sum[32] ^ e_neg;
    assign n_kin_a   = kneg ? -$signed({1'b0, km}) : $signed({1'b0, km});
    assign n_wrong_a = (r_pv > 0) ? -$signed({1'b0, r_amax}) : $signed({1'b0, r_amax});

    // Velocity and position integration.
    assign amag   = mag33($signed({r_a[DW-1], r_a}));
    assign vnmag  = mag33($signed({r_vn[DW-1], r_vn}));
    assign p_r32  = r_prod + HALF32;
    assign vlim35 = $signed({4'b0, r_vlim});

    always_comb begin
        step35 = $signed({1'b0, p_r32[65:32]});
        if (i_cmd.op == OP_VEL) begin
            vraw = pv35 + (r_a[DW-1] ? -step35 : step35);
        end else begin
            vraw = pv35;
        end
        praw = pp35 + (r_vn[DW-1] ? -step35 : step35);
    end

    always_comb begin
        if (vraw > vlim35) begin
            n_vn = $signed({1'b0, r_vlim});
        end else if (vraw < -vlim35) begin
            n_vn = -$signed({1'b0, r_vlim});
        end else begin
            n_vn = vraw[DW-1:0];
        end
        if (praw > $signed({3'b0, 1'b0, {(DW-1){1'b1}}})) begin
            n_pn = {1'b0, {(DW-1){1'b1}}};
        end else if (praw < -$signed({3'b0, 1'b1, {(DW-1){1'b0}}})) begin
            n_pn = {1'b1, {(DW-1){1'b0}}};
        end else begin
            n_pn = praw[DW-1:0];
        end
    end

    assign dv    = $signed({r_vn[DW-1], r_vn}) - $signed({r_pv[DW-1], r_pv});
    assign dvmag = mag33(dv);

    // Applied acceleration from the divider quotient.
    always_comb begin
        if (r_ts == '0) begin
            n_app = '0;
        end else if (r_dvneg) begin
            n_app = r_ovf ? {1'b1, {(DW-1){1'b0}}} : -$signed({1'b0, r_quo});
        end else begin
            n_app = r_ovf ? {1'b0, {(DW-1){1'b1}}} : $signed({1'b0, r_quo});
        end
    end

    // Divider operands and one restoring step.
    always_comb begin
        if (i_cmd.op == OP_KDIV_INIT) begin
            div_n = r_prod[64:0];
            div_d = {r_emag, 1'b0};
        end else begin
            div_n = {dvmag, 32'b0};
            div_d = {2'b0, r_ts};
        end
    end

    assign div_t  = {r_rem, r_nlo[30]};
    assign div_ge = div_t >= {1'b0, r_den};

    // Configuration and plan state; reset loads the default limits and clears the plan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amax <= LIM_W'(6553600);
            r_vlim <= LIM_W'(655360);
            r_wn   <= LIM_W'(1310720);
            r_ts   <= TS_W'(4294967);
            r_pp   <= '0;
            r_pv   <= '0;
            r_la   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACCEL: r_amax <= i_cfg_data[LIM_W-1:0];
                    CFG_VLIM:  r_vlim <= i_cfg_data[LIM_W-1:0];
                    CFG_WN:    r_wn   <= i_cfg_data[LIM_W-1:0];
                    CFG_TS:    r_ts   <= i_cfg_data;
                    default:   r_ts   <= r_ts;
                endcase
            end
            if ((i_cmd.op == OP_CAP) && !i_operation) begin
                r_pp <= i_goal_position;
                r_pv <= i_goal_velocity;
                r_la <= '0;
            end else if (i_cmd.op == OP_COMMIT) begin
                r_pp <= r_pn;
                r_pv <= r_vn;
                r_la <= n_app;
            end
        end
    end

    // Working registers, sequenced by the command.
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        unique case (i_cmd.op)
            OP_CAP: begin
                r_ga     <= i_goal_accel;
                r_gvmag  <= c_gvmag;
                r_e      <= c_e;
                r_ve     <= c_ve;
                r_sum    <= c_sum;
                r_emag   <= mag33(c_e);
                r_vemag  <= mag33(c_ve);
                r_summag <= mag33(c_sum);
            end
            OP_MUL_VE2: begin
                r_p1 <= r_prod[64:0];
            end
            OP_MUL_THR: begin
                r_tc <= ({1'b0, r_p1} >= r_prod);
            end
            OP_KDIV_INIT, OP_POS: begin
                r_ovf <= (div_n >= {div_d, 31'b0});
                r_rem <= div_n[64:31];
                r_nlo <= div_n[30:0];
                r_den <= div_d;
                r_quo <= '0;
                if (i_cmd.op == OP_POS) begin
                    r_pn    <= n_pn;
                    r_dvneg <= dv[32];
                end
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? 34'(div_t - {1'b0, r_den}) : div_t[33:0];
                r_nlo <= {r_nlo[29:0], 1'b0};
                r_quo <= {r_quo[29:0], div_ge};
            end
            OP_KIN_ACC: begin
                r_a <= n_kin_a;
            end
            OP_WRONG_ACC: begin
                r_a <= n_wrong_a;
            end
            OP_SAVE_W2: begin
                r_w2 <= p_r16[61:16];
            end
            OP_MUL_W2HI: begin
                r_acc <= {13'b0, r_prod};
            end
            OP_MUL_DAMP: begin
                r_acc <= r_acc + {r_prod[46:0], 32'b0};
            end
            OP_SAVE_T1: begin
                r_t1 <= t1s;
            end
            OP_TRACK_ACC: begin
                r_a <= n_track_a;
            end
            OP_VEL: begin
                r_vn <= n_vn;
            end
            OP_FIN: begin
                r_o_pos <= r_pp;
                r_o_vel <= r_pv;
                r_o_acc <= r_la;
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    assign o_planned_position = r_o_pos;
    assign o_planned_velocity = r_o_vel;
    assign o_applied_accel    = r_o_acc;

endmodule

// ===== rtl/core/constrained_trajectory_planner_core.sv =====
// Top level of the constrained trajectory planner core.
// Depends on ctp_pkg, the channel interfaces, ctp_ctrl and ctp_datapath.
//
// The core handles one request at a time. A load request goes from capture
// straight to loading the result. A planning step follows the tracking law,
// brakes in the wrong direction or brakes kinematically, on one shared 33x33
// multiplier and one restoring divider that yields a bit a cycle; with
// kinematic braking its 31-step division replaces the tracking products, and
// the division for the applied acceleration is skipped when the time step is zero.
// The next request is taken as soon as the result is in the output register,
// even while that result waits. Configuration writes are always ready and are meant for idle.
module constrained_trajectory_planner_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ctp_in_if.sink   i_in,
    ctp_out_if.source o_out,
    ctp_cfg_if.sink  i_cfg
);
    import ctp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    // Sequencer.
    ctp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Arithmetic and state.
    ctp_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_operation        (i_in.operation),
        .i_goal_position    (i_in.goal_position),
        .i_goal_velocity    (i_in.goal_velocity),
        .i_goal_accel       (i_in.goal_accel),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .o_planned_position (o_out.planned_position),
        .o_planned_velocity (o_out.planned_velocity),
        .o_applied_accel    (o_out.applied_accel)
    );

endmodule

// ===== rtl/core/ctp_checker.sv =====
// Port-level checker of the planner core and its bind to the top level.
// Depends on ctp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [ctp_pkg::DW-1:0] i_pos,
    input logic signed [ctp_pkg::DW-1:0] i_vel,
    input logic signed [ctp_pkg::DW-1:0] i_acc
);
    import ctp_pkg::*;

    // A stalled result stays offered and unchanged.
    `CTP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `CTP_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_pos) && $stable(i_vel) && $stable(i_acc))
    // Only one request is in work at a time.
    `CTP_ASSERT_NXT(a_one_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // Loading a result returns the sequencer to idle.
    `CTP_ASSERT_IMP(a_fin_idle, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready)

endmodule

bind constrained_trajectory_planner_core ctp_checker u_ctp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pos       (o_out.planned_position),
    .i_vel       (o_out.planned_velocity),
    .i_acc       (o_out.applied_accel)
);
